// ===== src/clt_pkg.sv =====
// Shared constants, codes and types of the command line tokenizer.
package clt_pkg;

    // Limits of the tokenizer.
    localparam int unsigned MAX_ARGS      = 8;
    localparam int unsigned MAX_ARG_CHARS = 63;

    // Widths of the internal counters.
    localparam int unsigned ARGS_W  = $clog2(MAX_ARGS + 1);
    localparam int unsigned CHARS_W = $clog2(MAX_ARG_CHARS + 1);

    // Widths of the transaction fields.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned CNT_W  = 4;

    // Result queue geometry.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QA_W   = $clog2(QDEPTH);
    localparam int unsigned QC_W   = $clog2(QDEPTH + 1);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // Parser modes.
    localparam int unsigned MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_SKIP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PLAIN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUOTED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ESCAPE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CUTQ   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FULL   = 3'd5;

    // Characters with a special meaning.
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  arg_index;
        logic [POS_W-1:0]  char_pos;
        logic [BYTE_W-1:0] out_char;
        logic [CNT_W-1:0]  arg_count;
        logic              last;
    } t_res;

    // Results of one parsed byte, handed to the result queue.
    typedef struct packed {
        logic [1:0] num;
        t_res       res0;
        t_res       res1;
    } t_push;

endpackage

// ===== src/clt_if.sv =====
// Channel interfaces of the command line tokenizer.
interface clt_in_if;
    import clt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface clt_out_if;
    import clt_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  arg_index;
    logic [POS_W-1:0]  char_pos;
    logic [BYTE_W-1:0] out_char;
    logic [CNT_W-1:0]  arg_count;
    logic              last;

    modport source (output valid, output kind, output arg_index, output char_pos,
                    output out_char, output arg_count, output last, input ready);
    modport sink (input valid, input kind, input arg_index, input char_pos,
                  input out_char, input arg_count, input last, output ready);
endinterface

// ===== src/command_line_tokenizer_core.sv =====
// Top level of the command line tokenizer.
//
// The block reads a command line one byte per input transaction; byte 0 ends
// the line and returns the parser to its starting state. It splits the line
// into at most 8 arguments separated by runs of spaces, honors double quotes
// (with backslash escapes inside them, backslash-n giving a newline), cuts an
// argument at 63 characters and ignores everything after the eighth argument
// until the line ends. Each input byte yields zero, one or two output
// transactions: one per argument character, one per closed argument and one
// at line end carrying the argument count; the final one of a byte has last
// set. A byte is taken every cycle while the input side does not stall. It
// is decoded straight out of the input register once the queue has room,
// and its results are written into a four-entry result queue at the end
// of that cycle, from which they leave one per cycle while the consumer
// is ready. The input side stalls only while the queue holds more than two
// results, which happens when the consumer stalls or when bytes that give two
// results (a cut, or line end with an argument open) arrive faster than one
// result per cycle can drain.
module command_line_tokenizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clt_in_if.sink    i_in,
    clt_out_if.source o_out
);
    import clt_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              step;
    logic              space;
    t_push             push;
    t_res              res;

    // The held byte is parsed once the queue can take both possible results.
    assign step       = r_in_vld && space;
    assign i_in.ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    clt_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    clt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    // Queue head drives the output transaction fields.
    assign o_out.kind      = res.kind;
    assign o_out.arg_index = res.arg_index;
    assign o_out.char_pos  = res.char_pos;
    assign o_out.out_char  = res.out_char;
    assign o_out.arg_count = res.arg_count;
    assign o_out.last      = res.last;

endmodule

// ===== src/clt_parser.sv =====
// Parser state and the per-byte decode that yields up to two results.
module clt_parser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [clt_pkg::BYTE_W-1:0] i_byte,
    output clt_pkg::t_push           o_push
);
    import clt_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [ARGS_W-1:0]  r_args;
    logic [CHARS_W-1:0] r_chars;
    logic [MODE_W-1:0]  n_mode;
    logic [ARGS_W-1:0]  n_args;
    logic [CHARS_W-1:0] n_chars;

    logic               do_char;
    logic               do_close;
    logic [BYTE_W-1:0]  ch;
    logic [CHARS_W-1:0] pos;
    logic [CHARS_W:0]   pos_inc;
    logic [ARGS_W-1:0]  args_inc;
    logic               full;
    logic [MODE_W-1:0]  close_mode;
    t_push              push;

    always_comb begin
        n_mode     = r_mode;
        n_args     = r_args;
        n_chars    = r_chars;
        do_char    = 1'b0;
        do_close   = 1'b0;
        ch         = i_byte;
        pos        = r_chars;
        close_mode = MODE_SKIP;
        push       = '0;
        args_inc   = r_args + ARGS_W'(1);
        full       = (32'(args_inc) >= MAX_ARGS);
        pos_inc    = '0;

        if (i_byte == CH_NUL) begin
            // End of line: close an open argument, report the count, reset.
            if (r_mode == MODE_PLAIN || r_mode == MODE_QUOTED || r_mode == MODE_ESCAPE) begin
                push.num            = 2'd2;
                push.res0.kind      = KIND_CLOSE;
                push.res0.arg_index = IDX_W'(r_args);
                push.res1.kind      = KIND_END;
                push.res1.arg_count = CNT_W'(args_inc);
            end else begin
                push.num            = 2'd1;
                push.res0.kind      = KIND_END;
                push.res0.arg_count = CNT_W'(r_args);
            end
            n_mode  = MODE_SKIP;
            n_args  = '0;
            n_chars = '0;
        end else begin
            unique case (r_mode) inside
                MODE_PLAIN: begin
                    if (i_byte == CH_SPACE) begin
                        do_close = 1'b1;
                    end else begin
                        do_char = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (i_byte == CH_QUOTE) begin
                        do_close = 1'b1;
                    end else if (i_byte == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        do_char    = 1'b1;
                        close_mode = MODE_CUTQ;
                    end
                end
                MODE_ESCAPE: begin
                    n_mode     = MODE_QUOTED;
                    do_char    = 1'b1;
                    close_mode = MODE_CUTQ;
                    ch         = (i_byte == CH_N) ? CH_NL : i_byte;
                end
                MODE_CUTQ, MODE_SKIP: begin
                    if (r_mode == MODE_CUTQ && i_byte == CH_QUOTE) begin
                        // Closing quote right after a cut is swallowed.
                        n_mode = MODE_SKIP;
                    end else if (i_byte == CH_SPACE) begin
                        n_mode = MODE_SKIP;
                    end else if (i_byte == CH_QUOTE) begin
                        n_chars = '0;
                        n_mode  = MODE_QUOTED;
                    end else begin
                        n_mode  = MODE_PLAIN;
                        pos     = '0;
                        do_char = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (do_char) begin
                pos_inc             = {1'b0, pos} + (CHARS_W + 1)'(1);
                push.res0.kind      = KIND_CHAR;
                push.res0.arg_index = IDX_W'(r_args);
                push.res0.char_pos  = POS_W'(pos);
                push.res0.out_char  = ch;
                if (32'(pos_inc) >= MAX_ARG_CHARS) begin
                    // The argument reached its length limit and closes now.
                    push.num            = 2'd2;
                    push.res1.kind      = KIND_CLOSE;
                    push.res1.arg_index = IDX_W'(r_args);
                    n_args              = args_inc;
                    n_chars             = '0;
                    n_mode              = full ? MODE_FULL : close_mode;
                end else begin
                    push.num = 2'd1;
                    n_chars  = CHARS_W'(pos_inc);
                end
            end

            if (do_close) begin
                push.num            = 2'd1;
                push.res0.kind      = KIND_CLOSE;
                push.res0.arg_index = IDX_W'(r_args);
                n_args              = args_inc;
                n_chars             = '0;
                n_mode              = full ? MODE_FULL : close_mode;
            end
        end

        if (push.num == 2'd1) begin
            push.res0.last = 1'b1;
        end
        if (push.num == 2'd2) begin
            push.res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SKIP;
            r_args  <= '0;
            r_chars <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_args  <= n_args;
            r_chars <= n_chars;
        end
    end

    always_comb begin
        o_push = push;
        if (!i_step) begin
            o_push.num = 2'd0;
        end
    end

endmodule

// ===== src/clt_outq.sv =====
// Small result queue that takes up to two results per cycle and gives one while the reader is ready.
module clt_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clt_pkg::t_push i_push,
    output logic           o_space,
    output logic           o_valid,
    input  logic           i_ready,
    output clt_pkg::t_res  o_res
);
    import clt_pkg::*;

    t_res            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wr;
    logic [QA_W-1:0] r_rd;
    logic [QC_W-1:0] r_cnt;
    logic            pop;
    logic [QA_W-1:0] wr_next;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // Room for a two-result byte, judged on the registered fill alone.
    assign o_space = (32'(r_cnt) <= QDEPTH - 2);
    assign wr_next = r_wr + QA_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QA_W'(i_push.num);
            r_rd  <= r_rd + QA_W'(pop);
            r_cnt <= r_cnt + QC_W'(i_push.num) - QC_W'(pop);
        end
    end

endmodule

// ===== src/clt_checker.sv =====
// Port-level checks of the command line tokenizer and their binding.
module clt_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [clt_pkg::KIND_W-1:0] i_kind,
    input logic [clt_pkg::IDX_W-1:0]  i_arg_index,
    input logic [clt_pkg::POS_W-1:0]  i_char_pos,
    input logic [clt_pkg::BYTE_W-1:0] i_out_char,
    input logic [clt_pkg::CNT_W-1:0]  i_arg_count,
    input logic                     i_last
);
    import clt_pkg::*;

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_out_char) && $stable(i_last))
        else $error("output transaction changed while stalled");

    a_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_CHAR || i_kind == KIND_CLOSE || i_kind == KIND_END))
        else $error("illegal result kind");

    a_noncharfields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_CHAR |-> i_out_char == '0 && i_char_pos == '0)
        else $error("character fields set on a non-character result");

    a_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_END |->
            i_last && i_arg_index == '0 && 32'(i_arg_count) <= MAX_ARGS)
        else $error("bad line end result");

endmodule

bind command_line_tokenizer_core clt_checker u_clt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_arg_index (o_out.arg_index),
    .i_char_pos  (o_out.char_pos),
    .i_out_char  (o_out.out_char),
    .i_arg_count (o_out.arg_count),
    .i_last      (o_out.last)
);

// ===== sim/tb_command_line_tokenizer_core.sv =====
// Self-checking testbench of the command line tokenizer core.
import clt_pkg::*;

// Scoreboard: a byte-level model of the tokenizer turns every accepted input
// byte into the output transactions it must cause; output transactions are
// then matched in order against those expectations.
class token_scoreboard;
    t_res              token_q[$];
    logic [MODE_W-1:0] mode;
    int unsigned       args_done;
    int unsigned       chars_in_arg;
    int unsigned       errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        mode         = MODE_SKIP;
        args_done    = 0;
        chars_in_arg = 0;
    endfunction

    function void push_res(logic [KIND_W-1:0] kind, int unsigned idx, int unsigned pos,
                           logic [BYTE_W-1:0] ch, int unsigned cnt);
        t_res r;
        r.kind      = kind;
        r.arg_index = idx[IDX_W-1:0];
        r.char_pos  = pos[POS_W-1:0];
        r.out_char  = ch;
        r.arg_count = cnt[CNT_W-1:0];
        r.last      = 1'b0;
        token_q.push_back(r);
    endfunction

    function void close_arg(logic [MODE_W-1:0] next_mode);
        push_res(KIND_CLOSE, args_done, 0, CH_NUL, 0);
        args_done++;
        chars_in_arg = 0;
        mode = (args_done >= MAX_ARGS) ? MODE_FULL : next_mode;
    endfunction

    // A character that fills the argument closes it in the same step.
    function void add_char(logic [BYTE_W-1:0] ch, logic [MODE_W-1:0] cut_mode);
        push_res(KIND_CHAR, args_done, chars_in_arg, ch, 0);
        chars_in_arg++;
        if (chars_in_arg >= MAX_ARG_CHARS) begin
            close_arg(cut_mode);
        end
    endfunction

    function void between_args(logic [BYTE_W-1:0] b);
        if (b == CH_SPACE) begin
            mode = MODE_SKIP;
        end else if (b == CH_QUOTE) begin
            chars_in_arg = 0;
            mode = MODE_QUOTED;
        end else begin
            chars_in_arg = 0;
            mode = MODE_PLAIN;
            add_char(b, MODE_SKIP);
        end
    endfunction

    // Returns 1 unless the byte is no line end and falls into a line that already holds all arguments.
    function bit parse_byte(logic [BYTE_W-1:0] b);
        int unsigned first;
        t_res        r;
        bit          live;
        live  = (mode != MODE_FULL) || (b == CH_NUL);
        first = token_q.size();
        if (b == CH_NUL) begin
            if (mode == MODE_PLAIN || mode == MODE_QUOTED || mode == MODE_ESCAPE) begin
                close_arg(MODE_SKIP);
            end
            push_res(KIND_END, 0, 0, CH_NUL, args_done);
            restart();
        end else begin
            case (mode)
                MODE_PLAIN: begin
                    if (b == CH_SPACE) close_arg(MODE_SKIP);
                    else add_char(b, MODE_SKIP);
                end
                MODE_QUOTED: begin
                    if (b == CH_QUOTE) close_arg(MODE_SKIP);
                    else if (b == CH_BSLASH) mode = MODE_ESCAPE;
                    else add_char(b, MODE_CUTQ);
                end
                MODE_ESCAPE: begin
                    mode = MODE_QUOTED;
                    add_char((b == CH_N) ? CH_NL : b, MODE_CUTQ);
                end
                MODE_CUTQ: begin
                    if (b == CH_QUOTE) mode = MODE_SKIP;
                    else between_args(b);
                end
                MODE_SKIP: begin
                    between_args(b);
                end
                default: begin
                end
            endcase
        end
        if (token_q.size() > first) begin
            r = token_q[token_q.size() - 1];
            r.last = 1'b1;
            token_q[token_q.size() - 1] = r;
        end
        return live;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_token(t_res got);
        t_res want;
        if (token_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %p", $time, got);
            errors++;
        end else begin
            want = token_q.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("arg_index", want.arg_index, got.arg_index);
            compare_field("char_pos", want.char_pos, got.char_pos);
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("arg_count", want.arg_count, got.arg_count);
            compare_field("last", want.last, got.last);
        end
    endfunction
endclass

module tb_command_line_tokenizer_core;

    // Cycles without any accepted transaction before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 4000;
    // Input bytes per phase, not counting bytes that a full line ignores.
    localparam int unsigned PHASE_ITEMS = 600;

    logic i_clk = 1'b0;
    logic i_rst_n;

    clt_in_if  in_if ();
    clt_out_if out_if ();

    command_line_tokenizer_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    token_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;
    t_res        got_token;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The consumer drops ready at random; the share of idle cycles follows the phase.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every output transaction goes straight to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_token.kind      = out_if.kind;
            got_token.arg_index = out_if.arg_index;
            got_token.char_pos  = out_if.char_pos;
            got_token.out_char  = out_if.out_char;
            got_token.arg_count = out_if.arg_count;
            got_token.last      = out_if.last;
            sb.check_token(got_token);
        end
    end

    // Watchdog: the run must keep moving on one side or the other.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and waits for the
    // transaction. Valid stays high after acceptance until the next call decides.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid   = 1'b0;
            in_if.in_byte = BYTE_W'($urandom);
            @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.in_byte = b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (sb.parse_byte(b)) items_sent++;
    endtask

    // Holds the input back until every predicted transaction has come out.
    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.token_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // Directed lines: plain and quoted arguments, both escape forms, an empty
    // quoted argument, a quote inside a plain argument, line end with an
    // argument open, line end right after a backslash and an empty line.
    task automatic send_directed();
        send_byte(8'h61);
        send_byte(8'hFF);
        send_string("  \"x \\n\\\"\"");
        send_byte(CH_NUL);
        send_string("\"\"b\"q");
        send_byte(CH_NUL);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_NUL);
        send_byte(CH_NUL);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(CH_NUL);
    endtask

    function automatic logic [BYTE_W-1:0] plain_char();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(1, 255)); while (b == CH_SPACE);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] quoted_char();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] escaped_char();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) return CH_N;
        if (pick < 50) return CH_QUOTE;
        if (pick < 60) return CH_BSLASH;
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // One command line. Most are well formed with random content: up to eleven
    // arguments, so the argument limit is hit, and now and then an argument
    // long enough to be cut. The rest are raw byte noise.
    task automatic send_line();
        int unsigned nargs;
        int unsigned len;
        bit          quoted;
        bit          last_arg;
        if ($urandom_range(99) < 10) begin
            len = $urandom_range(1, 40);
            repeat (len) send_byte(BYTE_W'($urandom));
            send_byte(CH_NUL);
            return;
        end
        nargs = $urandom_range(0, 11);
        repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
        for (int a = 0; a < nargs; a++) begin
            quoted   = ($urandom_range(99) < 40);
            last_arg = (a == nargs - 1);
            if ($urandom_range(99) < 5) len = $urandom_range(58, 66);
            else len = $urandom_range(quoted ? 0 : 1, 8);
            if (quoted) begin
                send_byte(CH_QUOTE);
                for (int c = 0; c < len; c++) begin
                    if ($urandom_range(99) < 15) begin
                        send_byte(CH_BSLASH);
                        send_byte(escaped_char());
                    end else begin
                        send_byte(quoted_char());
                    end
                end
                // The last quoted argument is sometimes left open at line end,
                // occasionally with a dangling backslash.
                if (!last_arg || $urandom_range(99) >= 20) begin
                    send_byte(CH_QUOTE);
                end else if ($urandom_range(99) < 50) begin
                    send_byte(CH_BSLASH);
                end
            end else begin
                repeat (len) send_byte(plain_char());
            end
            if (!last_arg || $urandom_range(99) < 50) begin
                repeat ($urandom_range(1, 3)) send_byte(CH_SPACE);
            end
        end
        send_byte(CH_NUL);
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        i_rst_n       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_directed();

        // Sender idles 30 percent, receiver 75, then the other way round,
        // then both at full rate. Each phase ends with the input held back
        // until the output side has caught up.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (items_sent < PHASE_ITEMS * (phase + 1)) begin
                send_line();
                if ($urandom_range(99) < 5) drain_results();
            end
            drain_results();
        end

        // Allow for the pipeline latency so that any spurious late
        // transaction is still caught.
        repeat (20) @(posedge i_clk);
        if (sb.token_q.size() != 0) begin
            $display("%0t: %0d transactions still expected, actual none",
                     $time, sb.token_q.size());
        end
        if (sb.errors == 0 && sb.token_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
